### rtl/core/bkmh_pkg.sv
`default_nettype none

package bkmh_pkg;

  localparam logic [31:0] GOLDEN = 32'h9e3779b9;
  localparam logic [31:0] SEED_RESET = 32'd3923095;

  localparam int BLOCK_BYTES = 12;
  localparam int BUF_DEPTH = BLOCK_BYTES - 1;
  localparam int FILL_W = $clog2(BLOCK_BYTES);
  localparam int MIX_ROWS = 9;
  localparam int PIPE_DEPTH = MIX_ROWS + 1;
  localparam int ROW_W = $clog2(MIX_ROWS);

  typedef logic [FILL_W-1:0] fill_t;
  typedef logic [ROW_W-1:0] row_t;

  localparam fill_t LAST_POS = fill_t'(BLOCK_BYTES - 1);

  typedef struct packed {
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] c;
  } words_t;

  typedef struct packed {
    logic   vld;
    logic   fin;
    words_t w;
  } job_t;

  function automatic words_t mix_row(words_t w, row_t row);
    words_t r;
    r = w;
    case (row)
      row_t'(0): r.a = (w.a - w.b - w.c) ^ (w.c >> 13);
      row_t'(1): r.b = (w.b - w.c - w.a) ^ (w.a << 8);
      row_t'(2): r.c = (w.c - w.a - w.b) ^ (w.b >> 13);
      row_t'(3): r.a = (w.a - w.b - w.c) ^ (w.c >> 12);
      row_t'(4): r.b = (w.b - w.c - w.a) ^ (w.a << 16);
      row_t'(5): r.c = (w.c - w.a - w.b) ^ (w.b >> 5);
      row_t'(6): r.a = (w.a - w.b - w.c) ^ (w.c >> 3);
      row_t'(7): r.b = (w.b - w.c - w.a) ^ (w.a << 10);
      row_t'(8): r.c = (w.c - w.a - w.b) ^ (w.b >> 15);
      default: r = w;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

### rtl/core/bkmh_if.sv
`default_nettype none

interface bkmh_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] key_byte;
  logic       last_byte;
  logic       empty_key;

  modport source (output valid, output key_byte, output last_byte, output empty_key,
                  input ready);
  modport sink (input valid, input key_byte, input last_byte, input empty_key,
                output ready);
endinterface

interface bkmh_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] hash_value;

  modport source (output valid, output hash_value, input ready);
  modport sink (input valid, input hash_value, output ready);
endinterface

interface bkmh_cfg_if;
  logic        valid;
  logic        ready;
  logic [31:0] initial_c;

  modport source (output valid, output initial_c, input ready);
  modport sink (input valid, input initial_c, output ready);
endinterface

`default_nettype wire

### rtl/core/bkmh_mix_pipe.sv
`default_nettype none

module bkmh_mix_pipe (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            en,
  input  wire bkmh_pkg::job_t  job_in,
  output bkmh_pkg::job_t       job_out
);

  logic [bkmh_pkg::PIPE_DEPTH-1:0] vld_r;
  logic [bkmh_pkg::PIPE_DEPTH-1:0] fin_r;
  bkmh_pkg::words_t                w_r [bkmh_pkg::PIPE_DEPTH];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[bkmh_pkg::PIPE_DEPTH-2:0], job_in.vld};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      fin_r <= {fin_r[bkmh_pkg::PIPE_DEPTH-2:0], job_in.fin};
      w_r[0] <= job_in.w;
      for (int k = 1; k < bkmh_pkg::PIPE_DEPTH; k++) begin
        w_r[k] <= bkmh_pkg::mix_row(w_r[k-1], bkmh_pkg::row_t'(k - 1));
      end
    end
  end

  assign job_out.vld = vld_r[bkmh_pkg::PIPE_DEPTH-1];
  assign job_out.fin = fin_r[bkmh_pkg::PIPE_DEPTH-1];
  assign job_out.w   = w_r[bkmh_pkg::PIPE_DEPTH-1];

endmodule

`default_nettype wire

### rtl/core/bkmh_gather.sv
`default_nettype none

module bkmh_gather (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             en,
  input  wire logic [31:0]      seed,
  bkmh_in_if.sink               in_ch,
  input  wire bkmh_pkg::job_t   ex,
  output bkmh_pkg::job_t        job
);

  logic                in_key_r;
  bkmh_pkg::fill_t     fill_r;
  logic [31:0]         len_r;
  logic [7:0]          buf_r [bkmh_pkg::BUF_DEPTH];
  bkmh_pkg::words_t    words_r;
  logic                blk_busy_r;
  logic                pend_r;
  bkmh_pkg::words_t    pend_add_r;

  logic                fire;
  logic                take;
  logic                has_byte;
  logic                start;
  logic                is_last;
  logic                blk_done;
  logic                exit_blk;
  logic                busy_now;
  bkmh_pkg::fill_t     fill_cur;
  bkmh_pkg::fill_t     fill_nxt;
  logic [31:0]         len_cur;
  logic [31:0]         len_nxt;
  logic [7:0]          view [bkmh_pkg::BLOCK_BYTES];
  bkmh_pkg::words_t    init_w;
  bkmh_pkg::words_t    base;
  bkmh_pkg::words_t    lanes;
  bkmh_pkg::words_t    tail_add;

  assign in_ch.ready = en && !pend_r;

  assign fire     = in_ch.valid && in_ch.ready;
  assign take     = fire && !(in_ch.empty_key && !in_ch.last_byte);
  assign has_byte = take && !in_ch.empty_key;
  assign is_last  = take && in_ch.last_byte;
  assign start    = !in_key_r;
  assign fill_cur = start ? '0 : fill_r;
  assign len_cur  = start ? '0 : len_r;
  assign blk_done = has_byte && (fill_cur == bkmh_pkg::LAST_POS);
  assign len_nxt  = len_cur + {31'd0, has_byte};
  assign fill_nxt = blk_done ? '0 : fill_cur + bkmh_pkg::fill_t'(has_byte);
  assign exit_blk = ex.vld && !ex.fin && en;
  assign busy_now = blk_busy_r && !exit_blk;

  assign init_w.a = bkmh_pkg::GOLDEN;
  assign init_w.b = bkmh_pkg::GOLDEN;
  assign init_w.c = seed;
  assign base = start ? init_w : (exit_blk ? ex.w : words_r);

  always_comb begin
    for (int i = 0; i < bkmh_pkg::BLOCK_BYTES; i++) begin
      view[i] = '0;
    end
    for (int i = 0; i < bkmh_pkg::BUF_DEPTH; i++) begin
      if (bkmh_pkg::fill_t'(i) < fill_cur) begin
        view[i] = buf_r[i];
      end
    end
    for (int i = 0; i < bkmh_pkg::BLOCK_BYTES; i++) begin
      if (has_byte && (fill_cur == bkmh_pkg::fill_t'(i))) begin
        view[i] = in_ch.key_byte;
      end
    end
  end

  assign lanes.a = {view[3], view[2], view[1], view[0]};
  assign lanes.b = {view[7], view[6], view[5], view[4]};
  assign lanes.c = {view[11], view[10], view[9], view[8]};

  always_comb begin
    if (blk_done) begin
      tail_add.a = '0;
      tail_add.b = '0;
      tail_add.c = len_nxt;
    end else begin
      tail_add.a = lanes.a;
      tail_add.b = lanes.b;
      tail_add.c = {view[10], view[9], view[8], 8'h00} + len_nxt;
    end
  end

  always_comb begin
    job.vld = 1'b0;
    job.fin = 1'b0;
    job.w   = base;
    if (pend_r && exit_blk) begin
      job.vld = 1'b1;
      job.fin = 1'b1;
      job.w.a = ex.w.a + pend_add_r.a;
      job.w.b = ex.w.b + pend_add_r.b;
      job.w.c = ex.w.c + pend_add_r.c;
    end else if (blk_done) begin
      job.vld = 1'b1;
      job.w.a = base.a + lanes.a;
      job.w.b = base.b + lanes.b;
      job.w.c = base.c + lanes.c;
    end else if (is_last && !busy_now) begin
      job.vld = 1'b1;
      job.fin = 1'b1;
      job.w.a = base.a + tail_add.a;
      job.w.b = base.b + tail_add.b;
      job.w.c = base.c + tail_add.c;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_key_r   <= 1'b0;
      fill_r     <= '0;
      len_r      <= '0;
      blk_busy_r <= 1'b0;
      pend_r     <= 1'b0;
    end else begin
      if (take) begin
        in_key_r <= !in_ch.last_byte;
        fill_r   <= fill_nxt;
        len_r    <= len_nxt;
      end
      if (blk_done) begin
        blk_busy_r <= 1'b1;
      end else if (exit_blk) begin
        blk_busy_r <= 1'b0;
      end
      if (is_last && (blk_done || busy_now)) begin
        pend_r <= 1'b1;
      end else if (exit_blk) begin
        pend_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (has_byte && !blk_done) begin
      for (int i = 0; i < bkmh_pkg::BUF_DEPTH; i++) begin
        if (fill_cur == bkmh_pkg::fill_t'(i)) begin
          buf_r[i] <= in_ch.key_byte;
        end
      end
    end
    if (is_last && (blk_done || busy_now)) begin
      pend_add_r <= tail_add;
    end
    if (exit_blk) begin
      words_r <= ex.w;
    end else if (take && start) begin
      words_r <= init_w;
    end
  end

endmodule

`default_nettype wire

### rtl/core/byte_key_mix_hash.sv
// Streams a key in one byte per item and returns the 32-bit three-word mixing hash of
// each key, one result per item flagged as the last of its key. An item is taken in
// every cycle unless the input holds off: the mix runs in a pipeline of an input
// register and one register per mixing row, entered once per twelve-byte block and once
// more at key end. If the last item completes a block, or follows one still in the
// pipeline, the input holds off until that block leaves the pipeline, and the result
// comes that much later. While a result waits at the output the whole pipeline and the
// input hold. The seed written on the configuration channel applies from the next key
// that starts.
`default_nettype none

module byte_key_mix_hash (
  input  wire logic  clk,
  input  wire logic  rst_n,
  bkmh_in_if.sink    in_ch,
  bkmh_out_if.source out_ch,
  bkmh_cfg_if.sink   cfg_ch
);

  logic            en;
  logic [31:0]     seed_r;
  logic            out_vld_r;
  logic [31:0]     hash_r;
  bkmh_pkg::job_t  job;
  bkmh_pkg::job_t  ex;

  assign en = !out_vld_r || out_ch.ready;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_r <= bkmh_pkg::SEED_RESET;
    end else if (cfg_ch.valid) begin
      seed_r <= cfg_ch.initial_c;
    end
  end

  bkmh_gather u_gather (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (en),
    .seed  (seed_r),
    .in_ch (in_ch),
    .ex    (ex),
    .job   (job)
  );

  bkmh_mix_pipe u_mix (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .job_in  (job),
    .job_out (ex)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (en && ex.vld && ex.fin) begin
      out_vld_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (en && ex.vld && ex.fin) begin
      hash_r <= ex.w.c;
    end
  end

  assign out_ch.valid      = out_vld_r;
  assign out_ch.hash_value = hash_r;

endmodule

`default_nettype wire
